FILE: hdl/csdo_pkg.sv
// csdo_pkg: shared types, codes and constants of the CANopen SDO/PDO client.
// No dependencies; imported by every module of the block.
package csdo_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] OP_SDO_WRITE = 3'd0;
  localparam logic [2:0] OP_SDO_READ  = 3'd1;
  localparam logic [2:0] OP_RX_FRAME  = 3'd2;
  localparam logic [2:0] OP_TICK      = 3'd3;
  localparam logic [2:0] OP_NMT       = 3'd4;
  localparam logic [2:0] OP_SYNC      = 3'd5;

  localparam logic [2:0] K_NONE      = 3'd0;
  localparam logic [2:0] K_READ      = 3'd1;
  localparam logic [2:0] K_SDO_DATA  = 3'd2;
  localparam logic [2:0] K_SDO_ABORT = 3'd3;
  localparam logic [2:0] K_TPDO      = 3'd4;
  localparam logic [2:0] K_TICK      = 3'd5;

  localparam logic [1:0] RS_VALUE   = 2'd0;
  localparam logic [1:0] RS_ABORT   = 2'd1;
  localparam logic [1:0] RS_TIMEOUT = 2'd2;

  localparam logic       CFG_NODE    = 1'b0;
  localparam logic       CFG_TIMEOUT = 1'b1;
  localparam logic [6:0] NODE_RESET    = 7'd1;
  localparam logic [7:0] TIMEOUT_RESET = 8'd20;

  localparam logic [10:0] ID_NMT    = 11'h000;
  localparam logic [10:0] ID_SYNC   = 11'h080;
  localparam logic [10:0] ID_TPDO1  = 11'h180;
  localparam logic [10:0] ID_TSDO   = 11'h580;
  localparam logic [10:0] ID_RSDO   = 11'h600;
  localparam logic [10:0] FUNC_MASK = 11'h780;

  localparam logic [7:0] CMD_DOWNLOAD = 8'h22;
  localparam logic [7:0] CMD_SIZE1    = 8'h0F;
  localparam logic [7:0] CMD_SIZE2    = 8'h0B;
  localparam logic [7:0] CMD_SIZE4    = 8'h03;
  localparam logic [7:0] CMD_UPLOAD   = 8'h40;
  localparam logic [7:0] CMD_ABORT    = 8'h80;

  localparam logic [15:0] IDX_STATUS   = 16'h6041;
  localparam logic [15:0] IDX_POSITION = 16'h6064;
  localparam int          TARGET_BIT   = 10;
  localparam logic [3:0]  TPDO_MIN_LEN = 4'd6;
  localparam logic [3:0]  DLC_SDO      = 4'd8;
  localparam logic [3:0]  DLC_NMT      = 4'd2;
  localparam logic [3:0]  DLC_SYNC     = 4'd0;

  typedef struct packed {
    logic [6:0] node_address;
    logic [7:0] read_timeout_ticks;
  } csdo_cfg_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] od_index;
    logic [7:0]  od_subindex;
    logic [31:0] write_value;
    logic [2:0]  write_size;
    logic [7:0]  nmt_command;
    logic [10:0] rx_id;
    logic [3:0]  rx_length;
    logic [63:0] rx_payload;
  } csdo_in_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [3:0]  tx_length;
    logic [63:0] tx_payload;
    logic [2:0]  kind;
    logic [15:0] idx;
    logic [7:0]  sub;
    logic [31:0] data;
    logic [15:0] stat;
    logic        is_status_obj;
    logic        is_pos_obj;
  } csdo_item_t;

  // result item; last member sits in the lowest bits
  typedef struct packed {
    logic        target_reached;
    logic        position_updated;
    logic [31:0] drive_position;
    logic [15:0] drive_status;
    logic [31:0] read_value;
    logic [1:0]  read_status;
    logic        read_done;
    logic [63:0] tx_payload;
    logic [3:0]  tx_length;
    logic [10:0] tx_id;
    logic        tx_valid;
  } csdo_out_t;

endpackage

FILE: hdl/csdo_front.sv
// csdo_front: decodes an incoming item, builds any frame to send and
// classifies received frames. Depends on csdo_pkg.
module csdo_front (
  input  csdo_pkg::csdo_cfg_t  cfg,
  input  csdo_pkg::csdo_in_t   in_item,
  output csdo_pkg::csdo_item_t item
);
  import csdo_pkg::*;

  logic [7:0]  dl_cmd;
  logic        node_hit;
  logic [10:0] func;
  logic [10:0] rsdo_id;

  assign node_hit = (in_item.rx_id[6:0] == cfg.node_address);
  assign func     = in_item.rx_id & FUNC_MASK;
  assign rsdo_id  = ID_RSDO + {4'd0, cfg.node_address};

  always_comb begin
    unique case (in_item.write_size)
      3'd1:    dl_cmd = CMD_DOWNLOAD | CMD_SIZE1;
      3'd2:    dl_cmd = CMD_DOWNLOAD | CMD_SIZE2;
      3'd4:    dl_cmd = CMD_DOWNLOAD | CMD_SIZE4;
      default: dl_cmd = CMD_DOWNLOAD;
    endcase
  end

  always_comb begin
    item               = '0;
    item.kind          = K_NONE;
    item.idx           = in_item.od_index;
    item.sub           = in_item.od_subindex;
    unique case (in_item.operation)
      OP_SDO_WRITE: begin
        item.tx_valid   = 1'b1;
        item.tx_id      = rsdo_id;
        item.tx_length  = DLC_SDO;
        item.tx_payload = {in_item.write_value, in_item.od_subindex,
                           in_item.od_index, dl_cmd};
      end
      OP_SDO_READ: begin
        item.tx_valid   = 1'b1;
        item.tx_id      = rsdo_id;
        item.tx_length  = DLC_SDO;
        item.tx_payload = {32'd0, in_item.od_subindex, in_item.od_index, CMD_UPLOAD};
        item.kind       = K_READ;
      end
      OP_RX_FRAME: begin
        item.idx  = in_item.rx_payload[23:8];
        item.sub  = in_item.rx_payload[31:24];
        item.data = in_item.rx_payload[63:32];
        item.stat = in_item.rx_payload[15:0];
        item.is_status_obj = (in_item.rx_payload[23:8] == IDX_STATUS) &&
                             (in_item.rx_payload[31:24] == 8'd0);
        item.is_pos_obj    = (in_item.rx_payload[23:8] == IDX_POSITION) &&
                             (in_item.rx_payload[31:24] == 8'd0);
        if (node_hit && func == ID_TSDO) begin
          item.kind = (in_item.rx_payload[7:0] == CMD_ABORT) ? K_SDO_ABORT : K_SDO_DATA;
        end else if (node_hit && func == ID_TPDO1 && in_item.rx_length >= TPDO_MIN_LEN) begin
          item.kind = K_TPDO;
          item.data = in_item.rx_payload[47:16];
        end
      end
      OP_TICK: begin
        item.kind = K_TICK;
      end
      OP_NMT: begin
        item.tx_valid   = 1'b1;
        item.tx_id      = ID_NMT;
        item.tx_length  = DLC_NMT;
        item.tx_payload = {48'd0, 1'b0, cfg.node_address, in_item.nmt_command};
      end
      OP_SYNC: begin
        item.tx_valid  = 1'b1;
        item.tx_id     = ID_SYNC;
        item.tx_length = DLC_SYNC;
      end
      default: begin
        item.kind = K_NONE;
      end
    endcase
  end

endmodule

FILE: hdl/csdo_queue.sv
// csdo_queue: short first-in first-out queue of classified items between
// front and back. Depends on csdo_pkg.
module csdo_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  csdo_pkg::csdo_item_t wr_item,
  output logic                 full,
  input  logic                 rd_en,
  output csdo_pkg::csdo_item_t rd_item,
  output logic                 empty
);
  import csdo_pkg::*;

  csdo_item_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: hdl/csdo_back.sv
// csdo_back: carries out classified items against the read and drive state
// and holds the result register. Depends on csdo_pkg.
module csdo_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csdo_pkg::csdo_cfg_t  cfg,
  input  logic                 q_valid,
  input  csdo_pkg::csdo_item_t q_item,
  output logic                 q_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csdo_pkg::csdo_out_t  out_item
);
  import csdo_pkg::*;

  logic        pending_r, pending_nxt;
  logic [15:0] aw_idx_r, aw_idx_nxt;
  logic [7:0]  aw_sub_r, aw_sub_nxt;
  logic [7:0]  wait_r, wait_nxt;
  logic [15:0] status_r, status_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  csdo_out_t   out_r, res;
  logic        match;
  logic [8:0]  wait_inc;

  assign q_take    = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign match     = pending_r && (q_item.idx == aw_idx_r) && (q_item.sub == aw_sub_r);
  assign wait_inc  = {1'b0, wait_r} + 9'd1;

  always_comb begin
    pending_nxt = pending_r;
    aw_idx_nxt  = aw_idx_r;
    aw_sub_nxt  = aw_sub_r;
    wait_nxt    = wait_r;
    status_nxt  = status_r;
    pos_nxt     = pos_r;
    res            = '0;
    res.tx_valid   = q_item.tx_valid;
    res.tx_id      = q_item.tx_id;
    res.tx_length  = q_item.tx_length;
    res.tx_payload = q_item.tx_payload;
    if (q_take) begin
      unique case (q_item.kind)
        K_READ: begin
          pending_nxt = 1'b1;
          aw_idx_nxt  = q_item.idx;
          aw_sub_nxt  = q_item.sub;
          wait_nxt    = 8'd0;
        end
        K_SDO_ABORT: begin
          if (match) begin
            res.read_done   = 1'b1;
            res.read_status = RS_ABORT;
            pending_nxt     = 1'b0;
          end
        end
        K_SDO_DATA: begin
          if (match) begin
            res.read_done   = 1'b1;
            res.read_status = RS_VALUE;
            res.read_value  = q_item.data;
            pending_nxt     = 1'b0;
          end
          if (q_item.is_status_obj) begin
            status_nxt         = q_item.data[15:0];
            res.target_reached = q_item.data[TARGET_BIT];
          end else if (q_item.is_pos_obj) begin
            pos_nxt              = q_item.data;
            res.position_updated = 1'b1;
          end
        end
        K_TPDO: begin
          status_nxt           = q_item.stat;
          pos_nxt              = q_item.data;
          res.position_updated = 1'b1;
          res.target_reached   = q_item.stat[TARGET_BIT];
        end
        K_TICK: begin
          if (pending_r) begin
            if (wait_inc >= {1'b0, cfg.read_timeout_ticks}) begin
              res.read_done   = 1'b1;
              res.read_status = RS_TIMEOUT;
              pending_nxt     = 1'b0;
              wait_nxt        = 8'd0;
            end else begin
              wait_nxt = wait_inc[7:0];
            end
          end
        end
        default: begin
          pending_nxt = pending_r;
        end
      endcase
    end
    res.drive_status   = status_nxt;
    res.drive_position = pos_nxt;
    if (q_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      aw_idx_r    <= '0;
      aw_sub_r    <= '0;
      wait_r      <= '0;
      status_r    <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      aw_idx_r    <= aw_idx_nxt;
      aw_sub_r    <= aw_sub_nxt;
      wait_r      <= wait_nxt;
      status_r    <= status_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      out_r <= res;
    end
  end

  a_read_arms: assert property (@(posedge clk) disable iff (!rst_n)
    q_take && q_item.kind == K_READ |=> pending_r)
    else $error("read request did not arm pending read");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    q_take && q_item.kind == K_TICK && !pending_r |=> !out_r.read_done)
    else $error("tick finished a read that was not pending");

  a_stores_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.drive_status == status_r && out_r.drive_position == pos_r)
    else $error("result does not show recorded drive state");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.read_status != RS_VALUE |-> out_r.read_value == 32'd0)
    else $error("non-zero value on abort or timeout");

endmodule

FILE: hdl/canopen_sdo_pdo_client.sv
// canopen_sdo_pdo_client: top level of the CANopen master for one drive node.
// Depends on csdo_pkg, csdo_front, csdo_queue and csdo_back.
//
// Takes one item per clock on the in_ stream while in_tready is high (it drops
// when the two-entry queue is full) and returns exactly one result item per
// input on the out_ stream; an accepted item enters the queue at the accepting
// edge and moves into the output register when the back takes it, and one item
// per cycle is sustained while out_tready is held high. The front decodes each
// item and builds any NMT, SYNC or SDO frame; the back tracks the pending SDO
// upload, its tick timeout and the recorded status word and position. Write
// node_address (index 0) and read_timeout_ticks (index 1) on the cfg_ port
// only while no item is in flight; cfg_ready is always high.
module canopen_sdo_pdo_client (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] od_index, [23:16] od_subindex, [55:24] write_value,
  // [58:56] write_size, [66:59] nmt_command, [77:67] rx_id,
  // [81:78] rx_length, [145:82] rx_payload, [151:146] zero
  input  logic [151:0] in_tdata,
  // [2:0] operation
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] tx_valid, [11:1] tx_id, [15:12] tx_length, [79:16] tx_payload,
  // [80] read_done, [82:81] read_status, [114:83] read_value,
  // [130:115] drive_status, [162:131] drive_position,
  // [163] position_updated, [164] target_reached, [167:165] zero
  output logic [167:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data
);
  import csdo_pkg::*;

  logic [6:0]  node_r, node_nxt;
  logic [7:0]  tmo_r, tmo_nxt;
  csdo_cfg_t   cfg;
  csdo_in_t    in_item;
  csdo_item_t  f_item, q_item;
  logic        q_full, q_empty, q_take, wr_en;
  csdo_out_t   res;

  assign cfg_ready = 1'b1;
  assign cfg.node_address       = node_r;
  assign cfg.read_timeout_ticks = tmo_r;

  always_comb begin
    node_nxt = node_r;
    tmo_nxt  = tmo_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NODE:    node_nxt = cfg_data[6:0];
        CFG_TIMEOUT: tmo_nxt  = cfg_data;
        default:     node_nxt = node_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= NODE_RESET;
      tmo_r  <= TIMEOUT_RESET;
    end else begin
      node_r <= node_nxt;
      tmo_r  <= tmo_nxt;
    end
  end

  assign in_item.operation   = in_tuser;
  assign in_item.od_index    = in_tdata[15:0];
  assign in_item.od_subindex = in_tdata[23:16];
  assign in_item.write_value = in_tdata[55:24];
  assign in_item.write_size  = in_tdata[58:56];
  assign in_item.nmt_command = in_tdata[66:59];
  assign in_item.rx_id       = in_tdata[77:67];
  assign in_item.rx_length   = in_tdata[81:78];
  assign in_item.rx_payload  = in_tdata[145:82];

  assign in_tready = !q_full;
  assign wr_en     = in_tvalid && !q_full;

  csdo_front u_front (
    .cfg     (cfg),
    .in_item (in_item),
    .item    (f_item)
  );

  csdo_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_item (f_item),
    .full    (q_full),
    .rd_en   (q_take),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  csdo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (!q_empty),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res)
  );

  assign out_tdata = {3'd0, res};

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for canopen_sdo_pdo_client: directed and random items on the in_
// stream, each result predicted in a small scoreboard class and checked field by field.
// Depends on csdo_pkg and the canopen_sdo_pdo_client RTL.
`timescale 1ns / 1ps

import csdo_pkg::*;

class node_link_scoreboard;
  logic [6:0]  node_id;
  logic [7:0]  timeout_limit;
  bit          read_open;
  logic [15:0] want_idx;
  logic [7:0]  want_sub;
  logic [7:0]  ticks_seen;
  logic [15:0] drive_word;
  logic [31:0] position;
  csdo_out_t   frames_due[$];
  int          mismatches;

  function new();
    node_id       = NODE_RESET;
    timeout_limit = TIMEOUT_RESET;
    read_open     = 1'b0;
    want_idx      = '0;
    want_sub      = '0;
    ticks_seen    = '0;
    drive_word    = '0;
    position      = '0;
    mismatches    = 0;
  endfunction

  function void set_reg(logic idx, logic [7:0] v);
    if (idx == CFG_NODE) begin
      node_id = v[6:0];
    end else begin
      timeout_limit = v;
    end
  endfunction

  function int pending();
    return frames_due.size();
  endfunction

  function void note_request(csdo_in_t r);
    csdo_out_t   e;
    logic [7:0]  cmd;
    logic [15:0] aidx;
    logic [7:0]  asub;
    logic [31:0] data;
    bit          hit;
    e = '0;
    case (r.operation)
      OP_SDO_WRITE: begin
        cmd = CMD_DOWNLOAD;
        case (r.write_size)
          3'd1: cmd |= CMD_SIZE1;
          3'd2: cmd |= CMD_SIZE2;
          3'd4: cmd |= CMD_SIZE4;
          default: ;
        endcase
        e.tx_valid   = 1'b1;
        e.tx_id      = ID_RSDO + {4'd0, node_id};
        e.tx_length  = DLC_SDO;
        e.tx_payload = {r.write_value, r.od_subindex, r.od_index, cmd};
      end
      OP_SDO_READ: begin
        e.tx_valid   = 1'b1;
        e.tx_id      = ID_RSDO + {4'd0, node_id};
        e.tx_length  = DLC_SDO;
        e.tx_payload = {32'h0, r.od_subindex, r.od_index, CMD_UPLOAD};
        read_open    = 1'b1;
        want_idx     = r.od_index;
        want_sub     = r.od_subindex;
        ticks_seen   = '0;
      end
      OP_RX_FRAME: begin
        if (r.rx_id[6:0] == node_id) begin
          if ((r.rx_id & FUNC_MASK) == ID_TSDO) begin
            cmd  = r.rx_payload[7:0];
            aidx = r.rx_payload[23:8];
            asub = r.rx_payload[31:24];
            data = r.rx_payload[63:32];
            hit  = read_open && aidx == want_idx && asub == want_sub;
            if (cmd == CMD_ABORT) begin
              if (hit) begin
                e.read_done   = 1'b1;
                e.read_status = RS_ABORT;
                read_open     = 1'b0;
              end
            end else begin
              if (hit) begin
                e.read_done   = 1'b1;
                e.read_status = RS_VALUE;
                e.read_value  = data;
                read_open     = 1'b0;
              end
              if (aidx == IDX_STATUS && asub == 8'h00) begin
                drive_word       = data[15:0];
                e.target_reached = drive_word[TARGET_BIT];
              end else if (aidx == IDX_POSITION && asub == 8'h00) begin
                position           = data;
                e.position_updated = 1'b1;
              end
            end
          end else if ((r.rx_id & FUNC_MASK) == ID_TPDO1 && r.rx_length >= TPDO_MIN_LEN) begin
            drive_word         = r.rx_payload[15:0];
            position           = r.rx_payload[47:16];
            e.position_updated = 1'b1;
            e.target_reached   = drive_word[TARGET_BIT];
          end
        end
      end
      OP_TICK: begin
        if (read_open) begin
          if (ticks_seen + 32'd1 >= timeout_limit) begin
            e.read_done   = 1'b1;
            e.read_status = RS_TIMEOUT;
            read_open     = 1'b0;
            ticks_seen    = '0;
          end else begin
            ticks_seen = ticks_seen + 8'd1;
          end
        end
      end
      OP_NMT: begin
        e.tx_valid   = 1'b1;
        e.tx_id      = ID_NMT;
        e.tx_length  = DLC_NMT;
        e.tx_payload = {48'h0, 1'b0, node_id, r.nmt_command};
      end
      OP_SYNC: begin
        e.tx_valid  = 1'b1;
        e.tx_id     = ID_SYNC;
        e.tx_length = DLC_SYNC;
      end
      default: ;
    endcase
    e.drive_status   = drive_word;
    e.drive_position = position;
    frames_due.push_back(e);
  endfunction

  function void compare(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  function void check_result(logic [167:0] raw);
    csdo_out_t got;
    csdo_out_t want;
    got = raw[164:0];
    if (frames_due.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result item, expected none got %h", $time, raw);
      return;
    end
    want = frames_due.pop_front();
    compare("tx_valid", 64'(want.tx_valid), 64'(got.tx_valid));
    compare("tx_id", 64'(want.tx_id), 64'(got.tx_id));
    compare("tx_length", 64'(want.tx_length), 64'(got.tx_length));
    compare("tx_payload", want.tx_payload, got.tx_payload);
    compare("read_done", 64'(want.read_done), 64'(got.read_done));
    compare("read_status", 64'(want.read_status), 64'(got.read_status));
    compare("read_value", 64'(want.read_value), 64'(got.read_value));
    compare("drive_status", 64'(want.drive_status), 64'(got.drive_status));
    compare("drive_position", 64'(want.drive_position), 64'(got.drive_position));
    compare("position_updated", 64'(want.position_updated), 64'(got.position_updated));
    compare("target_reached", 64'(want.target_reached), 64'(got.target_reached));
    compare("padding", 64'h0, 64'(raw[167:165]));
  endfunction
endclass

module testbench;
  localparam logic [2:0] OP_SPARE_LO  = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;
  localparam logic [7:0] CMD_UPLOAD_4B = 8'h43;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata   = '0;
  logic [2:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic         cfg_index  = 1'b0;
  logic [7:0]   cfg_data   = '0;

  csdo_in_t    held_req  = '0;
  bit          idle_on   = 1'b1;
  logic [6:0]  node_now  = NODE_RESET;
  logic [15:0] last_idx  = '0;
  logic [7:0]  last_sub  = '0;

  node_link_scoreboard board = new();

  canopen_sdo_pdo_client u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= !idle_on || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_request(held_req);
      if (out_tvalid && out_tready) board.check_result(out_tdata);
    end
  end

  function automatic logic [63:0] sdo_reply(logic [7:0] cmd, logic [15:0] idx,
                                            logic [7:0] sub, logic [31:0] data);
    return {data, sub, idx, cmd};
  endfunction

  // identifier of a frame sent by the current node
  function automatic logic [10:0] from_node(logic [10:0] func);
    return func | {4'd0, node_now};
  endfunction

  function automatic csdo_in_t build(logic [2:0] op, logic [15:0] idx, logic [7:0] sub,
                                     logic [31:0] wval, logic [2:0] wsize, logic [7:0] nmt,
                                     logic [10:0] rid, logic [3:0] rlen, logic [63:0] pay);
    csdo_in_t r;
    r.operation   = op;
    r.od_index    = idx;
    r.od_subindex = sub;
    r.write_value = wval;
    r.write_size  = wsize;
    r.nmt_command = nmt;
    r.rx_id       = rid;
    r.rx_length   = rlen;
    r.rx_payload  = pay;
    return r;
  endfunction

  // mostly well-formed traffic: answers aimed at the open read, status/position
  // objects and TPDO1 from our node, with some foreign-node and random frames
  function automatic csdo_in_t rand_req();
    csdo_in_t   r;
    int         pick;
    int         k;
    logic [7:0] cmd;
    r = build(3'($urandom), 16'($urandom), 8'($urandom), $urandom, 3'($urandom),
              8'($urandom), 11'($urandom), 4'($urandom), {$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.operation = OP_SDO_WRITE;
    end else if (pick < 22) begin
      r.operation = OP_SDO_READ;
      k = $urandom_range(3);
      if (k == 0) r.od_index = IDX_STATUS;
      else if (k == 1) r.od_index = IDX_POSITION;
      if (k != 3) r.od_subindex = 8'h00;
      last_idx = r.od_index;
      last_sub = r.od_subindex;
    end else if (pick < 60) begin
      r.operation = OP_RX_FRAME;
      cmd = ($urandom_range(2) == 0) ? CMD_ABORT : 8'($urandom);
      k = $urandom_range(99);
      if (k < 45) begin
        r.rx_id      = from_node(ID_TSDO);
        r.rx_payload = sdo_reply(cmd, last_idx, last_sub, $urandom);
      end else if (k < 60) begin
        r.rx_id      = from_node(ID_TSDO);
        r.rx_payload = sdo_reply(cmd, $urandom_range(1) ? IDX_STATUS : IDX_POSITION,
                                 ($urandom_range(4) == 0) ? 8'($urandom) : 8'h00, $urandom);
      end else if (k < 75) begin
        r.rx_id = from_node(ID_TPDO1);
      end else if (k < 88) begin
        r.rx_id = ($urandom_range(1) ? ID_TSDO : ID_TPDO1) |
                  {4'd0, node_now ^ 7'($urandom_range(1, 127))};
      end
    end else if (pick < 88) begin
      r.operation = OP_TICK;
    end else if (pick < 94) begin
      r.operation = OP_NMT;
    end else if (pick < 98) begin
      r.operation = OP_SYNC;
    end else begin
      r.operation = $urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI;
    end
    return r;
  endfunction

  task automatic push_request(input csdo_in_t r);
    if (idle_on && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.operation;
    in_tdata  <= {6'h0, r.rx_payload, r.rx_length, r.rx_id, r.nmt_command, r.write_size,
                  r.write_value, r.od_subindex, r.od_index};
    held_req  <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] node_cfg, input logic [7:0] limit_cfg,
                           input bit gaps, input int count);
    drain();
    write_reg(CFG_NODE, node_cfg);
    write_reg(CFG_TIMEOUT, limit_cfg);
    node_now = node_cfg[6:0];
    idle_on <= gaps;
    repeat (count) push_request(rand_req());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // download sizes and field extremes, then NMT, SYNC and the spare operations
    push_request(build(OP_SDO_WRITE, 16'h0000, 8'h00, 32'h0000_0000, 3'd1, 8'h00,
                       11'h000, 4'd0, 64'h0));
    push_request(build(OP_SDO_WRITE, 16'hFFFF, 8'hFF, 32'h7FFF_FFFF, 3'd2, 8'hFF,
                       11'h7FF, 4'd15, '1));
    push_request(build(OP_SDO_WRITE, 16'h1234, 8'h01, 32'h8000_0000, 3'd4, 8'h00,
                       11'h000, 4'd0, 64'h0));
    push_request(build(OP_SDO_WRITE, 16'h6040, 8'h00, 32'hFFFF_FFFF, 3'd0, 8'h00,
                       11'h000, 4'd0, 64'h0));
    push_request(build(OP_SDO_WRITE, 16'h6040, 8'h00, 32'h0000_000F, 3'd3, 8'h00,
                       11'h000, 4'd0, 64'h0));
    push_request(build(OP_SDO_WRITE, 16'h6040, 8'h00, 32'h0000_0006, 3'd7, 8'h00,
                       11'h000, 4'd0, 64'h0));
    push_request(build(OP_NMT, 16'h0, 8'h0, 32'h0, 3'd0, 8'h01, 11'h000, 4'd0, 64'h0));
    push_request(build(OP_NMT, 16'h0, 8'h0, 32'h0, 3'd0, 8'hFF, 11'h000, 4'd0, 64'h0));
    push_request(build(OP_SYNC, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, 11'h000, 4'd0, 64'h0));
    push_request(build(OP_SPARE_LO, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, 11'h000, 4'd0, 64'h0));
    push_request(build(OP_SPARE_HI, '1, '1, '1, '1, '1, '1, '1, '1));

    // read answered with a value, then one aborted, with a foreign-node answer between
    push_request(build(OP_SDO_READ, IDX_STATUS, 8'h00, 32'h0, 3'd0, 8'h00, 11'h000, 4'd0,
                       64'h0));
    push_request(build(OP_RX_FRAME, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, from_node(ID_TSDO),
                       4'd8, sdo_reply(CMD_UPLOAD_4B, IDX_STATUS, 8'h00, 32'h0000_0400)));
    push_request(build(OP_SDO_READ, IDX_POSITION, 8'h00, 32'h0, 3'd0, 8'h00, 11'h000, 4'd0,
                       64'h0));
    push_request(build(OP_RX_FRAME, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00,
                       ID_TSDO | {4'd0, node_now ^ 7'h03}, 4'd8,
                       sdo_reply(CMD_ABORT, IDX_POSITION, 8'h00, 32'h0609_0011)));
    push_request(build(OP_RX_FRAME, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, from_node(ID_TSDO),
                       4'd8, sdo_reply(CMD_ABORT, IDX_POSITION, 8'h00, 32'h0609_0011)));

    // second read replaces the first; stale answer must not match
    push_request(build(OP_SDO_READ, 16'h2000, 8'h01, 32'h0, 3'd0, 8'h00, 11'h000, 4'd0,
                       64'h0));
    push_request(build(OP_SDO_READ, IDX_POSITION, 8'h00, 32'h0, 3'd0, 8'h00, 11'h000, 4'd0,
                       64'h0));
    push_request(build(OP_RX_FRAME, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, from_node(ID_TSDO),
                       4'd3, sdo_reply(CMD_UPLOAD_4B, 16'h2000, 8'h01, 32'h1234_5678)));
    push_request(build(OP_RX_FRAME, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, from_node(ID_TSDO),
                       4'd8, sdo_reply(CMD_UPLOAD_4B, IDX_POSITION, 8'h00, 32'h8000_0000)));
    push_request(build(OP_TICK, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, 11'h000, 4'd0, 64'h0));

    // TPDO1: too short, minimum, DLC above 8; then an all-ones id from another node
    push_request(build(OP_RX_FRAME, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, from_node(ID_TPDO1),
                       4'd5, 64'h0000_1122_3344_0400));
    push_request(build(OP_RX_FRAME, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, from_node(ID_TPDO1),
                       4'd6, '1));
    push_request(build(OP_RX_FRAME, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, from_node(ID_TPDO1),
                       4'd15, 64'h0000_7FFF_FFFF_0000));
    push_request(build(OP_RX_FRAME, 16'h0, 8'h0, 32'h0, 3'd0, 8'h00, 11'h7FF, 4'd8, '1));

    run_phase(8'h7F, 8'hFF, 1'b1, 300);
    run_phase(8'h85, 8'h01, 1'b0, 300);
    run_phase(8'h00, 8'h00, 1'b1, 300);
    run_phase(8'h01, TIMEOUT_RESET, 1'b1, 300);
    run_phase(8'($urandom_range(1, 127)), 8'($urandom_range(2, 8)), 1'b1, 300);
    run_phase(8'h40, 8'h03, 1'b1, 300);
    drain();

    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
